/* hdl/swt_pkg.sv */
// ----------------------------------------------------------------------------
// swt_pkg: shell word tokenizer shared definitions
// Lexer state codes, result kinds, error codes, limits and result helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package swt_pkg;

	localparam int unsigned MAX_RESULTS = 3;

	localparam logic [9:0] MAX_TOKEN_LEN = 10'd511;
	localparam logic [5:0] MAX_TOKENS    = 6'd31;
	localparam logic [5:0] IDX_SAT       = 6'd31;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_NL     = 8'h0A;

	typedef enum logic [4:0] {
		LEX_NORMAL = 5'b00001,
		LEX_SQUOTE = 5'b00010,
		LEX_DQUOTE = 5'b00100,
		LEX_ESCAPE = 5'b01000,
		LEX_DQBACK = 5'b10000
	} lex_state_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_EOT  = 2'd1,
		KIND_PIPE = 2'd2,
		KIND_EOL  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_TOO_LONG = 2'd1,
		ERR_TOO_MANY = 2'd2
	} err_t;

	localparam logic MODE_BYTE = 1'b0;

	// lexer context held between requests
	typedef struct packed {
		lex_state_t  state;
		logic [9:0]  len;
		logic [5:0]  cnt;
	} lex_ctx_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_value;
		logic [4:0] token_index;
		logic [1:0] error_code;
		logic       last_of_run;
	} res_t;

	typedef res_t [MAX_RESULTS-1:0] res_vec_t;

	function automatic res_t make_res(kind_t k, logic [7:0] ch, err_t e, logic [5:0] cnt);
		res_t r;
		r.kind        = k;
		r.char_value  = ch;
		r.token_index = (cnt > IDX_SAT) ? IDX_SAT[4:0] : cnt[4:0];
		r.error_code  = e;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic err_t byte_err(logic [9:0] len, logic [5:0] cnt);
		err_t e;
		if (cnt >= MAX_TOKENS)
			e = ERR_TOO_MANY;
		else if (len >= MAX_TOKEN_LEN)
			e = ERR_TOO_LONG;
		else
			e = ERR_NONE;
		return e;
	endfunction

endpackage

`default_nettype wire

/* hdl/swt_if.sv */
// ----------------------------------------------------------------------------
// swt_if: tokenizer channel interfaces
// Valid/ready channels for line bytes in and token results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface swt_line_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_value;

	modport source (output valid, output mode, output byte_value, input ready);
	modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

interface swt_token_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_value;
	logic [4:0] token_index;
	logic [1:0] error_code;
	logic       last_of_run;

	modport source (output valid, output kind, output char_value, output token_index,
		output error_code, output last_of_run, input ready);
	modport sink   (input valid, input kind, input char_value, input token_index,
		input error_code, input last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/swt_lexer.sv */
// ----------------------------------------------------------------------------
// swt_lexer: one-byte lexer step
// Given the held context and one request, produce up to three results and
// the next context. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module swt_lexer (
	input  swt_pkg::lex_ctx_t ctx,
	input  logic              mode,
	input  logic [7:0]        byte_value,
	output swt_pkg::lex_ctx_t ctx_next,
	output swt_pkg::res_vec_t results,
	output logic [1:0]        num_results
);
	import swt_pkg::*;

	logic       put_bs, put_c, end_tok, pipe_tok, eol;
	lex_state_t st;
	logic [9:0] len;
	logic [5:0] cnt;
	logic [1:0] n;
	res_vec_t   res;

	// decode which actions this request takes
	always_comb begin
		put_bs   = 1'b0;
		put_c    = 1'b0;
		end_tok  = 1'b0;
		pipe_tok = 1'b0;
		eol      = 1'b0;
		st       = ctx.state;
		if (mode != MODE_BYTE) begin
			put_bs  = (ctx.state == LEX_DQBACK);
			end_tok = 1'b1;
			eol     = 1'b1;
			st      = LEX_NORMAL;
		end else begin
			case (ctx.state)
				LEX_SQUOTE: begin
					if (byte_value == CH_SQUOTE)
						st = LEX_NORMAL;
					else
						put_c = 1'b1;
				end
				LEX_DQUOTE: begin
					if (byte_value == CH_DQUOTE)
						st = LEX_NORMAL;
					else if (byte_value == CH_BSLASH)
						st = LEX_DQBACK;
					else
						put_c = 1'b1;
				end
				LEX_ESCAPE: begin
					put_c = 1'b1;
					st    = LEX_NORMAL;
				end
				LEX_DQBACK: begin
					put_bs = !(byte_value inside {CH_DQUOTE, CH_BSLASH, CH_BTICK,
						CH_DOLLAR, CH_STAR, CH_QMARK, CH_NL});
					put_c  = 1'b1;
					st     = LEX_DQUOTE;
				end
				default: begin
					st = LEX_NORMAL;
					if (byte_value == CH_SPACE) begin
						end_tok = 1'b1;
					end else if (byte_value == CH_PIPE) begin
						end_tok  = 1'b1;
						pipe_tok = 1'b1;
					end else if (byte_value == CH_SQUOTE) begin
						st = LEX_SQUOTE;
					end else if (byte_value == CH_DQUOTE) begin
						st = LEX_DQUOTE;
					end else if (byte_value == CH_BSLASH) begin
						st = LEX_ESCAPE;
					end else begin
						put_c = 1'b1;
					end
				end
			endcase
		end
	end

	// run the actions in order, at most three results
	always_comb begin
		len = ctx.len;
		cnt = ctx.cnt;
		n   = 2'd0;
		res = '0;
		if (put_bs) begin
			res[n] = make_res(KIND_CHAR, CH_BSLASH, byte_err(len, cnt), cnt);
			if (len < MAX_TOKEN_LEN)
				len = len + 10'd1;
			n = n + 2'd1;
		end
		if (put_c) begin
			res[n] = make_res(KIND_CHAR, byte_value, byte_err(len, cnt), cnt);
			if (len < MAX_TOKEN_LEN)
				len = len + 10'd1;
			n = n + 2'd1;
		end
		if (end_tok && (len != 10'd0)) begin
			if (cnt >= MAX_TOKENS) begin
				res[n] = make_res(KIND_EOT, 8'd0, ERR_TOO_MANY, cnt);
			end else begin
				res[n] = make_res(KIND_EOT, 8'd0, ERR_NONE, cnt);
				cnt    = cnt + 6'd1;
			end
			len = 10'd0;
			n   = n + 2'd1;
		end
		if (pipe_tok) begin
			if (cnt >= MAX_TOKENS) begin
				res[n] = make_res(KIND_PIPE, 8'd0, ERR_TOO_MANY, cnt);
			end else begin
				res[n] = make_res(KIND_PIPE, 8'd0, ERR_NONE, cnt);
				cnt    = cnt + 6'd1;
			end
			n = n + 2'd1;
		end
		if (eol) begin
			res[n] = make_res(KIND_EOL, 8'd0, ERR_NONE, cnt);
			n   = n + 2'd1;
			len = 10'd0;
			cnt = 6'd0;
		end
		if (n != 2'd0)
			res[n - 2'd1].last_of_run = 1'b1;
	end

	assign ctx_next.state = st;
	assign ctx_next.len   = len;
	assign ctx_next.cnt   = cnt;
	assign results        = res;
	assign num_results    = n;

endmodule

`default_nettype wire

/* hdl/shell_word_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// shell_word_tokenizer_top: streaming shell word tokenizer
// Splits a command line into tokens with quote, escape and pipe handling.
// ----------------------------------------------------------------------------
// Usage:
//   line  : one request per command-line byte (mode 0) or an end-of-line
//           marker (mode 1). Accepted when valid and ready are both high.
//   token : results, one per cycle while the receiver is ready: token bytes,
//           end-of-token marks, pipe tokens and the end-of-line mark;
//           last_of_run flags the final result of a request.
//   A request is lexed in the cycle it is accepted; its results (zero to
//   three) sit in a small result register and appear on token in the next
//   cycle. The next request is taken as soon as the last pending result is
//   leaving, so requests with zero or one result flow at one per cycle while
//   the receiver takes results.
//   Requests with no result (quotes, backslash, repeated spaces) still
//   update the lexer context.
//   When the receiver stalls, results hold and line.ready drops once the
//   pending result can no longer leave.
//   Reset clears the lexer context and empties the result register; the
//   block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_word_tokenizer_top (
	input  logic               clk,
	input  logic               arst_n,
	swt_line_if.sink           line,
	swt_token_if.source        token
);
	import swt_pkg::*;

	lex_ctx_t   ctx_q, ctx_next;
	res_vec_t   res_q, lex_res;
	logic [1:0] lex_n;
	logic [1:0] pend_q;
	logic       accept, pop;

	swt_lexer u_lexer (
		.ctx         (ctx_q),
		.mode        (line.mode),
		.byte_value  (line.byte_value),
		.ctx_next    (ctx_next),
		.results     (lex_res),
		.num_results (lex_n)
	);

	assign pop        = token.valid && token.ready;
	assign line.ready = (pend_q == 2'd0) || ((pend_q == 2'd1) && token.ready);
	assign accept     = line.valid && line.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state <= LEX_NORMAL;
			ctx_q.len   <= 10'd0;
			ctx_q.cnt   <= 6'd0;
			pend_q      <= 2'd0;
		end else begin
			if (accept) begin
				ctx_q  <= ctx_next;
				pend_q <= lex_n;
			end else if (pop) begin
				pend_q <= pend_q - 2'd1;
			end
		end
	end

	// result register: load on request, shift down as results leave
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= lex_res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	assign token.valid       = (pend_q != 2'd0);
	assign token.kind        = res_q[0].kind;
	assign token.char_value  = res_q[0].char_value;
	assign token.token_index = res_q[0].token_index;
	assign token.error_code  = res_q[0].error_code;
	assign token.last_of_run = res_q[0].last_of_run;

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (line.mode != MODE_BYTE)) |=>
		((ctx_q.state == LEX_NORMAL) && (ctx_q.len == 10'd0) && (ctx_q.cnt == 6'd0)))
		else $error("context not cleared after end of line");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q.len <= MAX_TOKEN_LEN) && (ctx_q.cnt <= MAX_TOKENS))
		else $error("token length or count beyond limit");

	a_eol_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token.valid && (token.kind == KIND_EOL)) |-> token.last_of_run)
		else $error("end of line result not last of run");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(token.valid && !token.last_of_run) |-> (pend_q > 2'd1))
		else $error("run ends without last_of_run");

endmodule

`default_nettype wire

/* tb/sv/swt_token_checker.sv */
// ----------------------------------------------------------------------------
// swt_token_checker: result checker for the shell word tokenizer
// Follows every accepted line request through its own lexer, queues the
// token results it must cause and compares each accepted result with them.
// ----------------------------------------------------------------------------
`default_nettype none

module swt_token_checker (
	input  logic  clk,
	input  logic  arst_n,
	swt_line_if   line,
	swt_token_if  token,
	output int    fail_count,
	output int    pending
);
	import swt_pkg::*;

	lex_state_t lex;
	logic [9:0] tok_len;
	logic [5:0] tok_cnt;
	res_t       run_res [MAX_RESULTS];
	int         run_n;
	res_t       expected_tokens [$];
	int         fails = 0;

	function automatic logic dq_escapable(logic [7:0] c);
		return c == CH_DQUOTE || c == CH_BSLASH || c == CH_BTICK || c == CH_DOLLAR ||
			c == CH_STAR || c == CH_QMARK || c == CH_NL;
	endfunction

	task automatic emit(kind_t k, logic [7:0] ch, err_t e);
		res_t r;
		r.kind        = k;
		r.char_value  = ch;
		r.token_index = (tok_cnt > IDX_SAT) ? IDX_SAT[4:0] : tok_cnt[4:0];
		r.error_code  = e;
		r.last_of_run = 1'b0;
		run_res[run_n] = r;
		run_n++;
	endtask

	// too many tokens wins over too long; length saturates at the limit
	task automatic add_char(logic [7:0] c);
		err_t e;
		if (tok_cnt >= MAX_TOKENS)
			e = ERR_TOO_MANY;
		else if (tok_len >= MAX_TOKEN_LEN)
			e = ERR_TOO_LONG;
		else
			e = ERR_NONE;
		if (tok_len < MAX_TOKEN_LEN)
			tok_len++;
		emit(KIND_CHAR, c, e);
	endtask

	task automatic close_count(kind_t k);
		if (tok_cnt >= MAX_TOKENS) begin
			emit(k, 8'h00, ERR_TOO_MANY);
		end else begin
			emit(k, 8'h00, ERR_NONE);
			tok_cnt++;
		end
	endtask

	task automatic finish_token();
		if (tok_len != 0) begin
			close_count(KIND_EOT);
			tok_len = '0;
		end
	endtask

	task automatic lex_request(logic m, logic [7:0] c);
		res_t r;
		run_n = 0;
		if (m != MODE_BYTE) begin
			if (lex == LEX_DQBACK)
				add_char(CH_BSLASH);
			finish_token();
			emit(KIND_EOL, 8'h00, ERR_NONE);
			lex     = LEX_NORMAL;
			tok_len = '0;
			tok_cnt = '0;
		end else begin
			case (lex)
				LEX_SQUOTE: begin
					if (c == CH_SQUOTE)
						lex = LEX_NORMAL;
					else
						add_char(c);
				end
				LEX_DQUOTE: begin
					if (c == CH_DQUOTE)
						lex = LEX_NORMAL;
					else if (c == CH_BSLASH)
						lex = LEX_DQBACK;
					else
						add_char(c);
				end
				LEX_ESCAPE: begin
					add_char(c);
					lex = LEX_NORMAL;
				end
				LEX_DQBACK: begin
					// keep the backslash unless it escapes something
					if (!dq_escapable(c))
						add_char(CH_BSLASH);
					add_char(c);
					lex = LEX_DQUOTE;
				end
				default: begin
					lex = LEX_NORMAL;
					if (c == CH_SPACE) begin
						finish_token();
					end else if (c == CH_PIPE) begin
						finish_token();
						close_count(KIND_PIPE);
					end else if (c == CH_SQUOTE) begin
						lex = LEX_SQUOTE;
					end else if (c == CH_DQUOTE) begin
						lex = LEX_DQUOTE;
					end else if (c == CH_BSLASH) begin
						lex = LEX_ESCAPE;
					end else begin
						add_char(c);
					end
				end
			endcase
		end
		for (int i = 0; i < run_n; i++) begin
			r = run_res[i];
			r.last_of_run = (i == run_n - 1);
			expected_tokens.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d",
				$time, name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			lex     = LEX_NORMAL;
			tok_len = '0;
			tok_cnt = '0;
			expected_tokens.delete();
		end else begin
			if (line.valid && line.ready)
				lex_request(line.mode, line.byte_value);
			if (token.valid && token.ready) begin
				if (expected_tokens.size() == 0) begin
					$display({"%0t: unexpected result, expected none, ",
						"got kind %0d char %0d idx %0d err %0d last %0d"},
						$time, token.kind, token.char_value, token.token_index,
						token.error_code, token.last_of_run);
					fails++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("kind", want.kind, token.kind);
					check_field("char_value", want.char_value, token.char_value);
					check_field("token_index", want.token_index, token.token_index);
					check_field("error_code", want.error_code, token.error_code);
					check_field("last_of_run", want.last_of_run, token.last_of_run);
				end
			end
		end
		fail_count <= fails;
		pending    <= expected_tokens.size();
	end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: shell word tokenizer testbench
// Feeds directed lines, an over-long token, an over-full line and random
// lines with quotes, escapes and pipes; stalls both channels at random and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import swt_pkg::*;

	localparam logic MODE_EOL        = ~MODE_BYTE;
	localparam int   HOLD_OFF_CYCLES = 300;
	localparam int   RANDOM_ITEMS    = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	bit   stall_long = 1'b0;
	int   fails;
	int   owed;

	swt_line_if  line_ch ();
	swt_token_if token_ch ();

	shell_word_tokenizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.token  (token_ch)
	);

	swt_token_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.line       (line_ch),
		.token      (token_ch),
		.fail_count (fails),
		.pending    (owed)
	);

	always #5 clk = ~clk;

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// hold valid through a gap only when there is one, so valid sees one update per step
	task automatic send_req(logic m, logic [7:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			line_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_ch.valid      <= 1'b1;
		line_ch.mode       <= m;
		line_ch.byte_value <= b;
		@(posedge clk);
		while (!line_ch.ready) @(posedge clk);
	endtask

	task automatic send_eol();
		send_req(MODE_EOL, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++)
			send_req(MODE_BYTE, s[i]);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_SPACE || c == CH_PIPE || c == CH_SQUOTE || c == CH_DQUOTE ||
			c == CH_BSLASH);
		return c;
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		int s;
		r = $urandom_range(0, 99);
		s = $urandom_range(0, 4);
		if (r < 12)
			return CH_SPACE;
		else if (r < 20)
			return CH_PIPE;
		else if (r < 26)
			return CH_SQUOTE;
		else if (r < 33)
			return CH_DQUOTE;
		else if (r < 42)
			return CH_BSLASH;
		else if (r < 50)
			return (s == 0) ? CH_BTICK : (s == 1) ? CH_DOLLAR : (s == 2) ? CH_STAR :
				(s == 3) ? CH_QMARK : CH_NL;
		else if (r < 82)
			return 8'(8'h61 + $urandom_range(0, 25));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// receiver: per result draw a hold-off, or take the long one when asked
	initial begin
		int hold;
		token_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (stall_long) begin
				stall_long = 1'b0;
				hold = HOLD_OFF_CYCLES;
			end else begin
				hold = calm ? 0 : $urandom_range(0, 19);
			end
			if (hold > 0) begin
				token_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			token_ch.ready <= 1'b1;
			do @(posedge clk); while (!token_ch.valid);
		end
	end

	initial begin
		int line_len;
		int random_items;
		bit pipe_heavy;
		line_ch.valid      <= 1'b0;
		line_ch.mode       <= MODE_BYTE;
		line_ch.byte_value <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain word, space, pipe
		send_str("a |b");
		send_eol();
		// single quotes keep pipe and double quote literal
		send_str("'x|\"'");
		send_eol();
		// escapable and plain bytes after a backslash in double quotes,
		// then end of line with the backslash still pending and the quote open
		send_str("\"\\\n\\q\\");
		send_eol();
		// escaped space outside quotes, then a dangling escape
		send_str("\\ \\");
		send_eol();
		send_req(MODE_BYTE, 8'h00);
		send_req(MODE_BYTE, 8'hFF);
		send_req(MODE_EOL, 8'hFF);

		// over-long token while the receiver holds off: fills the block
		calm = 1'b1;
		stall_long = 1'b1;
		for (int i = 0; i < 515; i++)
			send_req(MODE_BYTE, plain_byte());
		send_eol();
		// run past the token limit
		for (int i = 0; i < 20; i++) begin
			send_req(MODE_BYTE, plain_byte());
			send_req(MODE_BYTE, CH_PIPE);
		end
		send_str("yz");
		send_eol();
		calm = 1'b0;

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			pipe_heavy = ($urandom_range(0, 9) == 0);
			line_len = pipe_heavy ? $urandom_range(34, 44) : $urandom_range(0, 14);
			for (int i = 0; i < line_len; i++)
				send_req(MODE_BYTE, (pipe_heavy && $urandom_range(0, 2) == 0) ? CH_PIPE :
					pick_byte());
			send_eol();
			random_items += line_len + 1;
		end
		calm = 1'b0;
		line_ch.valid <= 1'b0;

		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

/* shell_word_tokenizer_top.f */
hdl/swt_pkg.sv
hdl/swt_if.sv
hdl/swt_lexer.sv
hdl/shell_word_tokenizer_top.sv
tb/sv/swt_token_checker.sv
tb/sv/tb.sv
